// File: src/ssdb_pkg.sv
// Types and constants shared by the spectrum smoothing block.
package ssdb_pkg;

    typedef logic [13:0]        bin_t;
    typedef logic signed [31:0] comp_t;
    typedef logic [23:0]        mag_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FFT_SIZE_LOG2 = 2'd0,
        CFG_SMOOTHING     = 2'd1,
        CFG_MIN_DB        = 2'd2,
        CFG_MAX_DB        = 2'd3
    } cfg_idx_t;

    localparam logic [3:0]         FFT_LOG2_RESET  = 4'd11;
    localparam logic [16:0]        SMOOTHING_RESET = 17'd52429;
    localparam logic signed [15:0] MIN_DB_RESET    = -16'sd25600;
    localparam logic signed [15:0] MAX_DB_RESET    = -16'sd7680;

    localparam logic [16:0]        K_ONE        = 17'd65536;
    localparam logic signed [19:0] DB_PER_LOG2  = 20'sd394566;
    localparam logic signed [21:0] LOG2_BIAS    = 22'sd1507328;
    localparam logic signed [41:0] DB_ROUND     = 42'sd8388608;
    localparam logic signed [16:0] DEN_EQUAL    = 17'sd256;

    localparam int SQRT_STEPS = 32;
    localparam int LOG_STEPS  = 16;
    localparam int DIV_STEPS  = 8;

endpackage

// File: src/spectrum_smoothing_db_bytes.sv
// Spectrum smoothing with per-bin magnitude store and decibel byte scaling.
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ------------------------------------------
//  input     in_valid / in_ready     bin_index, real_part, imag_part
//  output    out_valid / out_ready   out_bin, smoothed_magnitude, byte_level
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word is accepted every cycle unless the store is being cleared or
// the output stalls. The pipeline has squares, a 32-step square root, the
// read-modify-write of the magnitude store, 16 squaring steps for log2 and
// 8 division steps for the byte scaling, each step a stage of its own.
// After reset a clearing pass zeroes the store; the input is not ready
// until it ends, while configuration writes are taken as usual.
// When the output word is not taken, the whole pipeline holds.
module spectrum_smoothing_db_bytes #(
    parameter int MAX_BINS = 16384
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ssdb_pkg::bin_t     bin_index,
    input  ssdb_pkg::comp_t    real_part,
    input  ssdb_pkg::comp_t    imag_part,
    output logic               out_valid,
    input  logic               out_ready,
    output ssdb_pkg::bin_t     out_bin,
    output ssdb_pkg::mag_t     smoothed_magnitude,
    output logic [7:0]         byte_level,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  ssdb_pkg::cfg_idx_t cfg_index,
    input  logic [16:0]        cfg_data
);
    import ssdb_pkg::*;

    // MAX_BINS is a power of two, so the store slot is the low bits of the bin.
    localparam int SLOT_W = $clog2(MAX_BINS);

    // Stage numbers along the pipeline.
    localparam int ST_RT0  = 3;
    localparam int ST_MAG  = ST_RT0 + SQRT_STEPS + 1;
    localparam int ST_SM   = ST_MAG + 1;
    localparam int ST_NEW  = ST_SM + 1;
    localparam int ST_LOG0 = ST_NEW + 1;
    localparam int ST_P    = ST_LOG0 + LOG_STEPS + 1;
    localparam int ST_DB   = ST_P + 1;
    localparam int ST_DV0  = ST_DB + 1;
    localparam int LAST    = ST_DV0 + DIV_STEPS;

    // Configuration registers.
    logic [3:0]         fft_log2_reg;
    logic [16:0]        smooth_reg;
    logic signed [15:0] min_db_reg;
    logic signed [15:0] max_db_reg;

    // Pipeline control.
    logic [LAST:0]     v_reg;
    logic              en;
    logic              accept;
    logic [SLOT_W:0]   clr_cnt_reg;
    logic              clr_busy;

    // Payload carried along every stage.
    bin_t              bin_reg [0:LAST];

    // Absolute values and squares.
    logic [31:0]       are0_reg, aim0_reg, aim1_reg;
    logic [63:0]       sqr1_reg, sqr2_reg, sqi2_reg;

    // Square root, one result bit a stage.
    logic [63:0]       rt_rad_reg  [0:SQRT_STEPS];
    logic [33:0]       rt_rem_reg  [0:SQRT_STEPS];
    logic [31:0]       rt_root_reg [0:SQRT_STEPS];
    logic [33:0]       rt_rem_next  [0:SQRT_STEPS-1];
    logic [31:0]       rt_root_next [0:SQRT_STEPS-1];

    // Normalised magnitude and the store.
    logic [38:0]       mag_wide;
    mag_t              mag_next, mag_reg, mag37_reg;
    mag_t              mem [0:MAX_BINS-1];
    mag_t              rdata_reg;
    logic              fwd_v_reg;
    logic [SLOT_W-1:0] fwd_slot_reg;
    mag_t              fwd_val_reg;
    logic [SLOT_W-1:0] slot_mag, slot_sm;
    logic [16:0]       k_clamped;
    mag_t              prev_mag;
    logic signed [24:0] mag_diff;
    logic signed [42:0] mag_prod;
    logic signed [43:0] mag_acc;
    mag_t              new_mag;
    mag_t              sm_reg [ST_NEW:LAST];

    // log2 by repeated squaring.
    logic [4:0]        lm_next;
    logic [30:0]       lx_reg [0:LOG_STEPS];
    logic [4:0]        lm_reg [0:LOG_STEPS];
    logic [15:0]       lf_reg [0:LOG_STEPS];
    logic [30:0]       lx_next [0:LOG_STEPS-1];
    logic [15:0]       lf_next [0:LOG_STEPS-1];

    // Decibels and byte scaling.
    logic signed [21:0] lg_val;
    logic signed [41:0] p_next, p_reg, p_round;
    logic signed [17:0] db_next, db_reg;
    logic signed [18:0] db_diff;
    logic signed [26:0] num_val;
    logic signed [16:0] den_val;
    logic [25:0]       dv_rem_reg [0:DIV_STEPS];
    logic [15:0]       dv_den_reg [0:DIV_STEPS];
    logic [7:0]        dv_q_reg   [0:DIV_STEPS];
    logic              dv_neg_reg [0:DIV_STEPS];
    logic              dv_big_reg [0:DIV_STEPS];
    logic [25:0]       dv_rem_next [0:DIV_STEPS-1];
    logic [7:0]        dv_q_next   [0:DIV_STEPS-1];
    logic              dv_big_next;

    // The pipeline moves whenever the output stage is empty or being emptied.
    assign en        = !v_reg[LAST] || out_ready;
    assign clr_busy  = !clr_cnt_reg[SLOT_W];
    assign in_ready  = en && !clr_busy;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fft_log2_reg <= FFT_LOG2_RESET;
            smooth_reg   <= SMOOTHING_RESET;
            min_db_reg   <= MIN_DB_RESET;
            max_db_reg   <= MAX_DB_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FFT_SIZE_LOG2: fft_log2_reg <= cfg_data[3:0];
                CFG_SMOOTHING:     smooth_reg   <= cfg_data;
                CFG_MIN_DB:        min_db_reg   <= cfg_data[15:0];
                CFG_MAX_DB:        max_db_reg   <= cfg_data[15:0];
                default:           fft_log2_reg <= fft_log2_reg;
            endcase
        end
    end

    // Control state: valid bits, forwarding flag and the clearing counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg       <= '0;
            fwd_v_reg   <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (en)
            begin
                v_reg     <= {v_reg[LAST-1:0], accept};
                fwd_v_reg <= v_reg[ST_SM];
            end
            if (clr_busy)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // Square root steps: bring down two radicand bits, try root*4+1.
    always_comb
    begin
        for (int j = 0; j < SQRT_STEPS; j++)
        begin
            logic [33:0] rem_sh;
            logic [33:0] trial;
            rem_sh = {rt_rem_reg[j][31:0], rt_rad_reg[j][63:62]};
            trial  = {rt_root_reg[j], 2'b01};
            if (rem_sh >= trial)
            begin
                rt_rem_next[j]  = rem_sh - trial;
                rt_root_next[j] = {rt_root_reg[j][30:0], 1'b1};
            end
            else
            begin
                rt_rem_next[j]  = rem_sh;
                rt_root_next[j] = {rt_root_reg[j][30:0], 1'b0};
            end
        end
    end

    // Division by the FFT size, saturated to the Q1.23 range.
    always_comb
    begin
        if (fft_log2_reg <= 4'd7)
        begin
            mag_wide = 39'(rt_root_reg[SQRT_STEPS]) << (4'd7 - fft_log2_reg);
        end
        else
        begin
            mag_wide = 39'(rt_root_reg[SQRT_STEPS] >> (fft_log2_reg - 4'd7));
        end
        mag_next = (|mag_wide[38:24]) ? '1 : mag_wide[23:0];
    end

    // Smoothing written as mag + k*(prev - mag), which needs one multiplier.
    // The word one stage ahead wrote its slot at the edge this word's read
    // was taken, so a match with it takes the forwarded value.
    assign slot_mag  = bin_reg[ST_MAG][SLOT_W-1:0];
    assign slot_sm   = bin_reg[ST_SM][SLOT_W-1:0];
    assign k_clamped = (smooth_reg > K_ONE) ? K_ONE : smooth_reg;
    assign prev_mag  = (fwd_v_reg && fwd_slot_reg == slot_sm) ? fwd_val_reg : rdata_reg;
    assign mag_diff  = $signed({1'b0, prev_mag}) - $signed({1'b0, mag37_reg});
    assign mag_prod  = $signed({1'b0, k_clamped}) * mag_diff;
    assign mag_acc   = $signed({4'b0, mag37_reg, 16'b0}) + 44'(mag_prod) + 44'sd32768;
    assign new_mag   = mag_acc[39:16];

    always_comb
    begin
        lm_next = '0;
        for (int i = 0; i < 24; i++)
        begin
            if (sm_reg[ST_NEW][i])
            begin
                lm_next = 5'(i);
            end
        end
    end

    // One fraction bit of log2 per squaring of the normalised mantissa.
    always_comb
    begin
        for (int j = 0; j < LOG_STEPS; j++)
        begin
            logic [61:0] sq;
            sq = 62'(lx_reg[j]) * 62'(lx_reg[j]);
            if (sq[61])
            begin
                lx_next[j] = sq[61:31];
                lf_next[j] = {lf_reg[j][14:0], 1'b1};
            end
            else
            begin
                lx_next[j] = sq[60:30];
                lf_next[j] = {lf_reg[j][14:0], 1'b0};
            end
        end
    end

    // A zero magnitude has no logarithm and takes the lower limit instead.
    assign lg_val  = $signed({1'b0, lm_reg[LOG_STEPS], lf_reg[LOG_STEPS]}) - LOG2_BIAS;
    assign p_next  = lg_val * DB_PER_LOG2;
    assign p_round = p_reg + DB_ROUND;
    assign db_next = (sm_reg[ST_P] == '0) ? 18'(min_db_reg) : p_round[41:24];

    // Numerator and denominator, made so that the denominator is positive.
    always_comb
    begin
        db_diff = 19'(db_reg) - 19'(min_db_reg);
        num_val = (27'(db_diff) <<< 8) - 27'(db_diff);
        den_val = 17'(max_db_reg) - 17'(min_db_reg);
        if (den_val == '0)
        begin
            den_val = DEN_EQUAL;
        end
        if (den_val < 0)
        begin
            den_val = -den_val;
            num_val = -num_val;
        end
    end

    // Restoring division, one quotient bit a stage; a quotient above 255
    // is caught in the first stage.
    assign dv_big_next = dv_rem_reg[0] >= 26'({dv_den_reg[0], 8'b0});

    always_comb
    begin
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            logic [25:0] sh;
            sh = 26'(dv_den_reg[j]) << (DIV_STEPS - 1 - j);
            if (dv_rem_reg[j] >= sh)
            begin
                dv_rem_next[j] = dv_rem_reg[j] - sh;
                dv_q_next[j]   = {dv_q_reg[j][6:0], 1'b1};
            end
            else
            begin
                dv_rem_next[j] = dv_rem_reg[j];
                dv_q_next[j]   = {dv_q_reg[j][6:0], 1'b0};
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bin_reg[0] <= bin_index;
            for (int j = 0; j < LAST; j++)
            begin
                bin_reg[j+1] <= bin_reg[j];
            end
            are0_reg <= real_part[31] ? (~real_part + 32'd1) : real_part;
            if (bin_index == '0)
            begin
                aim0_reg <= '0;
            end
            else
            begin
                aim0_reg <= imag_part[31] ? (~imag_part + 32'd1) : imag_part;
            end
            sqr1_reg <= 64'(are0_reg) * 64'(are0_reg);
            aim1_reg <= aim0_reg;
            sqr2_reg <= sqr1_reg;
            sqi2_reg <= 64'(aim1_reg) * 64'(aim1_reg);

            rt_rad_reg[0]  <= sqr2_reg + sqi2_reg;
            rt_rem_reg[0]  <= '0;
            rt_root_reg[0] <= '0;
            for (int j = 0; j < SQRT_STEPS; j++)
            begin
                rt_rad_reg[j+1]  <= rt_rad_reg[j] << 2;
                rt_rem_reg[j+1]  <= rt_rem_next[j];
                rt_root_reg[j+1] <= rt_root_next[j];
            end

            mag_reg      <= mag_next;
            mag37_reg    <= mag_reg;
            fwd_slot_reg <= slot_sm;
            fwd_val_reg  <= new_mag;
            sm_reg[ST_NEW] <= new_mag;
            for (int j = ST_NEW; j < LAST; j++)
            begin
                sm_reg[j+1] <= sm_reg[j];
            end

            lx_reg[0] <= 31'(sm_reg[ST_NEW]) << (5'd30 - lm_next);
            lm_reg[0] <= lm_next;
            lf_reg[0] <= '0;
            for (int j = 0; j < LOG_STEPS; j++)
            begin
                lx_reg[j+1] <= lx_next[j];
                lm_reg[j+1] <= lm_reg[j];
                lf_reg[j+1] <= lf_next[j];
            end

            p_reg  <= p_next;
            db_reg <= db_next;

            dv_rem_reg[0] <= num_val[25:0];
            dv_den_reg[0] <= den_val[15:0];
            dv_q_reg[0]   <= '0;
            dv_neg_reg[0] <= num_val < 0;
            dv_big_reg[0] <= 1'b0;
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                dv_rem_reg[j+1] <= dv_rem_next[j];
                dv_den_reg[j+1] <= dv_den_reg[j];
                dv_q_reg[j+1]   <= dv_q_next[j];
                dv_neg_reg[j+1] <= dv_neg_reg[j];
                dv_big_reg[j+1] <= (j == 0) ? dv_big_next : dv_big_reg[j];
            end
        end
    end

    // Magnitude store: cleared after reset, then one read and one write a cycle.
    always_ff @(posedge clk)
    begin
        if (clr_busy)
        begin
            mem[clr_cnt_reg[SLOT_W-1:0]] <= '0;
        end
        else if (en && v_reg[ST_SM])
        begin
            mem[slot_sm] <= new_mag;
        end
        if (en)
        begin
            rdata_reg <= mem[slot_mag];
        end
    end

    assign out_valid          = v_reg[LAST];
    assign out_bin            = bin_reg[LAST];
    assign smoothed_magnitude = sm_reg[LAST];
    assign byte_level         = dv_neg_reg[DIV_STEPS] ? 8'd0 :
                                dv_big_reg[DIV_STEPS] ? 8'hFF : dv_q_reg[DIV_STEPS];

    // The pipeline stays empty for the whole clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n) clr_busy |-> v_reg == '0)
        else $error("word in flight while the store is being cleared");

    // An accepted word enters the first stage with its bin number.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v_reg[0] && bin_reg[0] == $past(bin_index))
        else $error("accepted word lost at the first stage");

    // With the store cleared and the output stage free, the input is ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!clr_busy && !out_valid) |-> in_ready)
        else $error("input held off with a free pipeline");

endmodule

// File: dv/spectrum_smoothing_db_bytes_tb.sv
// Self-checking testbench for the spectrum smoothing and decibel byte block.
`timescale 1ns / 100ps

module spectrum_smoothing_db_bytes_tb;

    import ssdb_pkg::*;

    localparam int BINS = 16384;

    // Idle cycles that cover any work still in flight before a register write
    // or at the end of the run.
    localparam int DRAIN_CYCLES = 200;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    bin_t        bin_index;
    comp_t       real_part;
    comp_t       imag_part;
    logic        out_valid;
    logic        out_ready;
    bin_t        out_bin;
    mag_t        smoothed_magnitude;
    logic [7:0]  byte_level;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [16:0] cfg_data;

    // Expected result of one word, held in arrival order.
    typedef struct packed {
        bin_t       bin;
        mag_t       mag;
        logic [7:0] level;
    } bin_result_t;

    bin_result_t       pending_results[$];
    int                error_count;
    bit                stall_enable;

    // The predictor's own copy of the registers and the magnitude store.
    logic [3:0]         pred_log2;
    logic [16:0]        pred_k;
    logic signed [15:0] pred_min_db;
    logic signed [15:0] pred_max_db;
    mag_t               pred_store [BINS];

    spectrum_smoothing_db_bytes dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .bin_index          (bin_index),
        .real_part          (real_part),
        .imag_part          (imag_part),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .out_bin            (out_bin),
        .smoothed_magnitude (smoothed_magnitude),
        .byte_level         (byte_level),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Integer square root of a 64-bit value, bit by bit.
    function automatic logic [63:0] root_of(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // log2 of a non-zero magnitude in Q16, fraction found by squaring.
    function automatic longint log2_of(mag_t v);
        int          top;
        logic [63:0] x;
        longint      frac;
        top = 0;
        for (int i = 0; i < 24; i++)
            if (v[i])
                top = i;
        x = 64'(v) << (30 - top);
        frac = 0;
        for (int i = 0; i < 16; i++)
        begin
            x = (x * x) >> 30;
            frac = frac << 1;
            if (x >= (64'd2 << 30))
            begin
                frac = frac | 1;
                x = x >> 1;
            end
        end
        return longint'(top) * 65536 + frac;
    endfunction

    // Works out the result of one bin and updates the predicted store.
    function automatic bin_result_t smooth_bin(bin_t b, comp_t re, comp_t im);
        bin_result_t r;
        longint      re_l;
        longint      im_l;
        logic [63:0] sq;
        logic [63:0] mag;
        logic [63:0] k;
        logic [63:0] acc;
        longint      mn;
        longint      mx;
        longint      db;
        longint      p;
        longint      num;
        longint      den;
        longint      q;
        re_l = re;
        im_l = (b == 0) ? 0 : im;
        sq = 64'(re_l * re_l) + 64'(im_l * im_l);
        mag = root_of(sq);
        if (pred_log2 <= 7)
            mag = mag << (7 - pred_log2);
        else
            mag = mag >> (pred_log2 - 7);
        if (mag > 64'hFFFFFF)
            mag = 64'hFFFFFF;
        k = (pred_k > K_ONE) ? 64'(K_ONE) : 64'(pred_k);
        acc = (k * pred_store[b] + (64'd65536 - k) * mag + 64'd32768) >> 16;
        if (acc > 64'hFFFFFF)
            acc = 64'hFFFFFF;
        pred_store[b] = acc[23:0];
        mn = pred_min_db;
        mx = pred_max_db;
        if (acc == 0)
            db = mn;
        else
        begin
            p = (log2_of(acc[23:0]) - 23 * 65536) * 394566;
            db = ((p + (longint'(1) << 40) + (longint'(1) << 23)) >>> 24) - (longint'(1) << 16);
        end
        num = 255 * (db - mn);
        den = mx - mn;
        if (den == 0)
            den = 256;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        if (num < 0)
            q = 0;
        else
        begin
            q = num / den;
            if (q > 255)
                q = 255;
        end
        r.bin = b;
        r.mag = acc[23:0];
        r.level = q[7:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Sends one word and records what it should produce. Valid stays high
    // into the next word when there is no gap; an idle wait drops it.
    task automatic send_bin(bin_t b, comp_t re, comp_t im);
        int gap;
        gap = random_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        bin_index <= b;
        real_part <= re;
        imag_part <= im;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(smooth_bin(b, re, im));
    endtask

    // Waits for every expected word, then for the pipeline to drain.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [16:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_FFT_SIZE_LOG2: pred_log2   = value[3:0];
            CFG_SMOOTHING:     pred_k      = value;
            CFG_MIN_DB:        pred_min_db = value[15:0];
            CFG_MAX_DB:        pred_max_db = value[15:0];
            default:           ;
        endcase
    endtask

    task automatic set_config(logic [3:0] l2, logic [16:0] k,
                              logic signed [15:0] mn, logic signed [15:0] mx);
        wait_idle();
        write_reg(CFG_FFT_SIZE_LOG2, 17'(l2));
        write_reg(CFG_SMOOTHING, k);
        write_reg(CFG_MIN_DB, 17'(mn[15:0]));
        write_reg(CFG_MAX_DB, 17'(mx[15:0]));
        cfg_valid <= 1'b0;
    endtask

    // Random component: full range now and then, otherwise moderate values.
    function automatic comp_t random_comp();
        case ($urandom_range(0, 3))
            0: return comp_t'($urandom());
            1: return comp_t'($signed($urandom_range(0, 65535)) - 32768);
            default: return comp_t'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh007FFFFF);
        endcase
    endfunction

    // Random bin: mostly a few bins so the smoothing history builds up.
    function automatic bin_t random_bin();
        if ($urandom_range(0, 3) == 0)
            return bin_t'($urandom());
        return bin_t'($urandom_range(0, 7));
    endfunction

    // Field extremes, bin zero's ignored imaginary part, and the store's edges.
    task automatic test_extremes();
        send_bin(14'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_bin(14'd0, 32'sh80000000, 32'sh12345678);
        send_bin(14'd1, 32'sh80000000, 32'sh80000000);
        send_bin(14'd1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_bin(14'd16383, 32'sd0, 32'sd0);
        send_bin(14'd16383, 32'sd65536, -32'sd65536);
        send_bin(14'd2, 32'sd0, 32'sd0);
        send_bin(14'd3, 32'sd1, 32'sd0);
        send_bin(14'h2AAA, 32'sh55555555, 32'shAAAAAAAA);
        send_bin(14'h1555, 32'shAAAAAAAA, 32'sh55555555);
    endtask

    // Equal limits, reversed limits, small FFT size and an oversized k.
    task automatic test_special_settings();
        set_config(4'd0, 17'd65536, 16'sd0, 16'sd0);
        send_bin(14'd5, 32'sd65536, 32'sd0);
        send_bin(14'd5, 32'sd0, 32'sd4096);
        set_config(4'd15, 17'd0, 16'sd32767, -16'sd32768);
        send_bin(14'd6, 32'sd1000000, 32'sd1000000);
        send_bin(14'd6, 32'sd100, 32'sd0);
        set_config(4'd2, 17'h1FFFF, -16'sd32768, 16'sd32767);
        send_bin(14'd7, 32'sd12345, -32'sd9999);
        send_bin(14'd7, 32'sh7FFFFFFF, 32'sd0);
        set_config(4'd5, 17'd1, -16'sd25600, -16'sd7680);
        send_bin(14'd8, 32'sd70000, 32'sd70000);
    endtask

    // Random words under a sequence of random settings.
    task automatic test_random_bins(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                set_config(4'($urandom_range(0, 15)),
                           ($urandom_range(0, 3) == 0) ? 17'($urandom()) :
                                                          17'($urandom_range(0, 65536)),
                           16'($urandom()), 16'($urandom()));
            send_bin(random_bin(), random_comp(), random_comp());
        end
    endtask

    // Output back-pressure, with spells of none at all.
    always @(posedge clk)
    begin
        if (!stall_enable || $urandom_range(0, 3) != 0)
            out_ready <= (random_gap() == 0) || !stall_enable;
        else
            out_ready <= 1'b0;
    end

    // Checks each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected out_bin", out_bin, -1);
            end
            else
            begin
                bin_result_t want;
                want = pending_results.pop_front();
                if (out_bin !== want.bin)
                    report_mismatch("out_bin", out_bin, want.bin);
                if (smoothed_magnitude !== want.mag)
                    report_mismatch("smoothed_magnitude", smoothed_magnitude, want.mag);
                if (byte_level !== want.level)
                    report_mismatch("byte_level", byte_level, want.level);
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        bin_index    = '0;
        real_part    = '0;
        imag_part    = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_FFT_SIZE_LOG2;
        cfg_data     = '0;
        error_count  = 0;
        stall_enable = 1'b1;
        pred_log2    = FFT_LOG2_RESET;
        pred_k       = SMOOTHING_RESET;
        pred_min_db  = MIN_DB_RESET;
        pred_max_db  = MAX_DB_RESET;
        for (int i = 0; i < BINS; i++)
            pred_store[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_special_settings();
        set_config(FFT_LOG2_RESET, SMOOTHING_RESET, MIN_DB_RESET, MAX_DB_RESET);
        test_random_bins(350);
        // A stretch with the receiver always ready.
        stall_enable = 1'b0;
        test_random_bins(350);
        stall_enable = 1'b1;
        wait_idle();

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Guard against a hung handshake, the clearing pass included.
    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
src/ssdb_pkg.sv
src/spectrum_smoothing_db_bytes.sv
dv/spectrum_smoothing_db_bytes_tb.sv
